FILE: hdl/rrtt_pkg.sv
// ----------------------------------------------------------------------------
// rrtt_pkg
// Shared constants, codes and controller/datapath interface types for the
// round-robin thread table.
// ----------------------------------------------------------------------------
package rrtt_pkg;

  localparam int THREAD_SLOTS_DEF = 128;
  localparam int ID_W             = 32;
  localparam int SLOT_FIELD_W     = 7;
  localparam int COUNT_FIELD_W    = 8;

  localparam logic [ID_W-1:0] MAIN_ID  = '0;
  localparam logic [ID_W-1:0] FIRST_ID = ID_W'(1);

  // slot states
  localparam logic [2:0] ST_FREE    = 3'd0;
  localparam logic [2:0] ST_READY   = 3'd1;
  localparam logic [2:0] ST_RUNNING = 3'd2;
  localparam logic [2:0] ST_EXITED  = 3'd3;
  localparam logic [2:0] ST_BLOCKED = 3'd4;

  // commands
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_CREATE = 2'd1;
  localparam logic [1:0] CMD_EXIT   = 2'd2;
  localparam logic [1:0] CMD_JOIN   = 2'd3;

  typedef enum logic [2:0] {
    A_ZERO,
    A_ACTIVE,
    A_TARGET,
    A_JOINER,
    A_SCAN,
    A_HIT
  } addr_sel_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_MAIN,
    WR_NEW,
    WR_EXIT,
    WR_WAKE,
    WR_BLOCK,
    WR_JOIN
  } wr_op_e;

  typedef enum logic {
    SCAN_FREE,
    SCAN_READY
  } scan_mode_e;

  typedef struct packed {
    logic       load_tgt;
    logic       clear_res;
    addr_sel_e  addr_sel;
    wr_op_e     wr_op;
    scan_mode_e scan_mode;
    logic       scan_init;
    logic       scan_step;
    logic       set_refused;
    logic       take_hit;
    logic       latch_tid;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic tgt_ok;
    logic rd_dead;
    logic rd_runnable;
    logic rd_blocked;
    logic rd_jv;
    logic hit;
    logic miss;
  } dp_stat_t;

endpackage

FILE: hdl/round_robin_thread_table_top.sv
// ----------------------------------------------------------------------------
// round_robin_thread_table_top
// Thread slot table with create, exit and join commands and a round-robin
// schedule step after every command.
// ----------------------------------------------------------------------------
// Busy for the whole of each command; the free-slot scan of a create and the
// round-robin scan each run until a match or until every candidate slot is
// checked, and busy is low while the done strobe is high.
// Each scan visits one slot a cycle and stops at its first match.
// One command at a time; the next may start in the cycle of the done strobe.
// Reset clears the slot states at once through per-slot valid flip-flops.
// ----------------------------------------------------------------------------
module round_robin_thread_table_top #(
  parameter int THREAD_SLOTS = rrtt_pkg::THREAD_SLOTS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          command_i,
  input  logic [rrtt_pkg::SLOT_FIELD_W-1:0]   target_slot_i,
  output logic                                done_o,
  output logic                                status_o,
  output logic [rrtt_pkg::SLOT_FIELD_W-1:0]   new_slot_o,
  output logic [rrtt_pkg::ID_W-1:0]           new_tid_o,
  output logic [rrtt_pkg::SLOT_FIELD_W-1:0]   active_slot_o,
  output logic [rrtt_pkg::ID_W-1:0]           active_thread_id_o,
  output logic [rrtt_pkg::COUNT_FIELD_W-1:0]  live_count_o
);
  import rrtt_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  rrtt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (command_i),
    .busy      (busy),
    .done_o    (done_o),
    .cmd_o     (dp_cmd),
    .stat_i    (dp_stat)
  );

  rrtt_datapath #(
    .THREAD_SLOTS (THREAD_SLOTS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (dp_cmd),
    .target_slot_i      (target_slot_i),
    .stat_o             (dp_stat),
    .status_o           (status_o),
    .new_slot_o         (new_slot_o),
    .new_tid_o          (new_tid_o),
    .active_slot_o      (active_slot_o),
    .active_thread_id_o (active_thread_id_o),
    .live_count_o       (live_count_o)
  );

endmodule

FILE: hdl/rrtt_datapath.sv
// ----------------------------------------------------------------------------
// rrtt_datapath
// Slot memories, scan counter, scheduler registers and result registers.
// ----------------------------------------------------------------------------
module rrtt_datapath #(
  parameter int THREAD_SLOTS = rrtt_pkg::THREAD_SLOTS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rrtt_pkg::dp_cmd_t                   cmd_i,
  input  logic [rrtt_pkg::SLOT_FIELD_W-1:0]   target_slot_i,
  output rrtt_pkg::dp_stat_t                  stat_o,
  output logic                                status_o,
  output logic [rrtt_pkg::SLOT_FIELD_W-1:0]   new_slot_o,
  output logic [rrtt_pkg::ID_W-1:0]           new_tid_o,
  output logic [rrtt_pkg::SLOT_FIELD_W-1:0]   active_slot_o,
  output logic [rrtt_pkg::ID_W-1:0]           active_thread_id_o,
  output logic [rrtt_pkg::COUNT_FIELD_W-1:0]  live_count_o
);
  import rrtt_pkg::*;

  localparam int SLOT_W  = $clog2(THREAD_SLOTS);
  localparam int CNT_W   = $clog2(THREAD_SLOTS + 1);
  localparam int IDX_W   = (SLOT_W > SLOT_FIELD_W ? SLOT_W : SLOT_FIELD_W) + 1;
  localparam int CNT_X_W = CNT_W > COUNT_FIELD_W ? CNT_W : COUNT_FIELD_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(THREAD_SLOTS - 1);
  localparam logic [CNT_W-1:0]  SLOTS_CNT = CNT_W'(THREAD_SLOTS);

  function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] v);
    return (v == LAST_SLOT) ? '0 : v + SLOT_W'(1);
  endfunction

  // slot stores, one field each so single fields can be written alone
  logic [2:0]        state_mem  [THREAD_SLOTS];
  logic [ID_W-1:0]   tid_mem    [THREAD_SLOTS];
  logic [2:0]        saved_mem  [THREAD_SLOTS];
  logic [SLOT_W-1:0] joiner_mem [THREAD_SLOTS];
  logic              jv_mem     [THREAD_SLOTS];
  logic [THREAD_SLOTS-1:0] vld_q;

  logic [2:0]        rd_state_raw, rd_saved_raw, rd_state;
  logic [ID_W-1:0]   rd_tid_raw;
  logic [SLOT_W-1:0] rd_joiner_raw;
  logic              rd_jv_raw, rd_vld_q, rd_jv;

  logic [SLOT_FIELD_W-1:0] tgt_q;
  logic [SLOT_W-1:0]       active_q, scan_q, chk_idx_q, joiner_q, addr;
  logic [CNT_W-1:0]        count_q, left_q;
  logic [ID_W-1:0]         next_id_q;
  logic                    chk_q, scan_match;

  logic                    res_status_q;
  logic [SLOT_W-1:0]       res_slot_q;
  logic [ID_W-1:0]         res_id_q, res_tid_q;

  logic                    we_state, we_tid, we_saved, we_joiner, we_jv;
  logic [2:0]              wd_state, wd_saved;
  logic [ID_W-1:0]         wd_tid;
  logic                    wd_jv;

  logic [IDX_W-1:0]        tgt_ext, act_ext, slot_ext;
  logic [CNT_X_W-1:0]      cnt_ext;

  assign tgt_ext  = IDX_W'(tgt_q);
  assign act_ext  = IDX_W'(active_q);
  assign slot_ext = IDX_W'(res_slot_q);
  assign cnt_ext  = CNT_X_W'(count_q);

  always_comb begin
    case (cmd_i.addr_sel)
      A_ACTIVE: addr = active_q;
      A_TARGET: addr = tgt_ext[SLOT_W-1:0];
      A_JOINER: addr = joiner_q;
      A_SCAN:   addr = scan_q;
      A_HIT:    addr = chk_idx_q;
      default:  addr = '0;
    endcase
  end

  assign rd_state = rd_vld_q ? rd_state_raw : ST_FREE;
  assign rd_jv    = rd_vld_q & rd_jv_raw;

  always_comb begin
    we_state = 1'b0;
    we_tid   = 1'b0;
    we_saved = 1'b0;
    we_joiner = 1'b0;
    we_jv    = 1'b0;
    wd_state = ST_FREE;
    wd_saved = ST_FREE;
    wd_tid   = next_id_q;
    wd_jv    = 1'b0;
    case (cmd_i.wr_op)
      WR_MAIN: begin
        we_state = 1'b1;
        wd_state = ST_READY;
        we_tid   = 1'b1;
        wd_tid   = MAIN_ID;
        we_jv    = 1'b1;
      end
      WR_NEW: begin
        we_state = 1'b1;
        wd_state = ST_READY;
        we_tid   = 1'b1;
        we_saved = 1'b1;
        we_jv    = 1'b1;
      end
      WR_EXIT: begin
        we_state = 1'b1;
        wd_state = ST_EXITED;
        we_jv    = 1'b1;
      end
      WR_WAKE: begin
        we_state = 1'b1;
        wd_state = rd_saved_raw;
      end
      WR_BLOCK: begin
        we_state = 1'b1;
        wd_state = ST_BLOCKED;
        we_saved = 1'b1;
        wd_saved = rd_state;
      end
      WR_JOIN: begin
        we_joiner = 1'b1;
        we_jv     = 1'b1;
        wd_jv     = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we_state)  state_mem[addr]  <= wd_state;
    if (we_tid)    tid_mem[addr]    <= wd_tid;
    if (we_saved)  saved_mem[addr]  <= wd_saved;
    if (we_joiner) joiner_mem[addr] <= active_q;
    if (we_jv)     jv_mem[addr]     <= wd_jv;
    rd_state_raw  <= state_mem[addr];
    rd_tid_raw    <= tid_mem[addr];
    rd_saved_raw  <= saved_mem[addr];
    rd_joiner_raw <= joiner_mem[addr];
    rd_jv_raw     <= jv_mem[addr];
  end

  // an entry without its valid bit reads as a free slot with no joiner
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_state) vld_q[addr] <= 1'b1;
      rd_vld_q <= vld_q[addr];
    end
  end

  assign scan_match = (cmd_i.scan_mode == SCAN_READY) ? (rd_state == ST_READY)
                    : (rd_state == ST_FREE || rd_state == ST_EXITED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
      left_q <= '0;
      chk_q  <= 1'b0;
    end else if (cmd_i.scan_init) begin
      scan_q <= (cmd_i.scan_mode == SCAN_READY) ? wrap_inc(active_q) : SLOT_W'(1);
      left_q <= (cmd_i.scan_mode == SCAN_READY) ? SLOTS_CNT : SLOTS_CNT - CNT_W'(1);
      chk_q  <= 1'b0;
    end else if (cmd_i.scan_step && left_q != '0) begin
      scan_q <= wrap_inc(scan_q);
      left_q <= left_q - CNT_W'(1);
      chk_q  <= 1'b1;
    end else begin
      chk_q  <= 1'b0;
    end
  end

  // index of the slot whose data arrives in the next cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step) chk_idx_q <= scan_q;
    if (cmd_i.wr_op == WR_EXIT) joiner_q <= rd_joiner_raw;
    if (cmd_i.load_tgt) tgt_q <= target_slot_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= '0;
      count_q   <= '0;
      next_id_q <= FIRST_ID;
    end else begin
      if (cmd_i.take_hit) active_q <= chk_idx_q;
      case (cmd_i.wr_op)
        WR_MAIN: count_q <= CNT_W'(1);
        WR_NEW: begin
          count_q   <= count_q + CNT_W'(1);
          next_id_q <= next_id_q + ID_W'(1);
        end
        WR_EXIT: if (count_q != '0) count_q <= count_q - CNT_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_res) begin
      res_status_q <= 1'b0;
      res_slot_q   <= '0;
      res_id_q     <= '0;
    end else if (cmd_i.set_refused) begin
      res_status_q <= 1'b1;
    end else if (cmd_i.wr_op == WR_NEW) begin
      res_slot_q <= chk_idx_q;
      res_id_q   <= next_id_q;
    end
    if (cmd_i.latch_tid) res_tid_q <= (rd_state == ST_FREE) ? MAIN_ID : rd_tid_raw;
  end

  always_comb begin
    stat_o.full        = (count_q == SLOTS_CNT);
    stat_o.empty       = (count_q == '0);
    stat_o.tgt_ok      = (tgt_ext < IDX_W'(THREAD_SLOTS));
    stat_o.rd_dead     = (rd_state == ST_FREE) || (rd_state == ST_EXITED);
    stat_o.rd_runnable = (rd_state == ST_READY) || (rd_state == ST_RUNNING);
    stat_o.rd_blocked  = (rd_state == ST_BLOCKED);
    stat_o.rd_jv       = rd_jv;
    stat_o.hit         = chk_q && scan_match;
    stat_o.miss        = !chk_q && (left_q == '0);
  end

  assign status_o           = res_status_q;
  assign new_slot_o         = slot_ext[SLOT_FIELD_W-1:0];
  assign new_tid_o          = res_id_q;
  assign active_slot_o      = act_ext[SLOT_FIELD_W-1:0];
  assign active_thread_id_o = res_tid_q;
  assign live_count_o       = cnt_ext[COUNT_FIELD_W-1:0];

endmodule

FILE: hdl/rrtt_ctrl.sv
// ----------------------------------------------------------------------------
// rrtt_ctrl
// Command sequencer: runs each command's memory accesses, the free-slot scan
// and the round-robin scan, then strobes the result.
// ----------------------------------------------------------------------------
module rrtt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic [1:0]         command_i,
  output logic               busy,
  output logic               done_o,
  output rrtt_pkg::dp_cmd_t  cmd_o,
  input  rrtt_pkg::dp_stat_t stat_i
);
  import rrtt_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_FS_INIT  = 4'd2;
  localparam logic [3:0] S_FS_RUN   = 4'd3;
  localparam logic [3:0] S_EX_CHK   = 4'd4;
  localparam logic [3:0] S_WK_RD    = 4'd5;
  localparam logic [3:0] S_WK_CHK   = 4'd6;
  localparam logic [3:0] S_JN_CHKT  = 4'd7;
  localparam logic [3:0] S_JN_CHKA  = 4'd8;
  localparam logic [3:0] S_JN_WRT   = 4'd9;
  localparam logic [3:0] S_RS_INIT  = 4'd10;
  localparam logic [3:0] S_RS_RUN   = 4'd11;
  localparam logic [3:0] S_ACT_RD   = 4'd12;
  localparam logic [3:0] S_ACT_CHK  = 4'd13;
  localparam logic [3:0] S_DONE     = 4'd14;

  logic [3:0] state_q, state_d;
  logic [1:0] cmd_q;
  logic       accept;

  assign busy   = (state_q != S_IDLE) && (state_q != S_DONE);
  assign done_o = (state_q == S_DONE);
  assign accept = start && !busy;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE, S_DONE: begin
        if (accept) begin
          cmd_o.load_tgt  = 1'b1;
          cmd_o.clear_res = 1'b1;
          state_d = S_DISPATCH;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DISPATCH: begin
        case (cmd_q)
          CMD_CREATE: begin
            if (stat_i.full) begin
              cmd_o.set_refused = 1'b1;
              state_d = S_RS_INIT;
            end else begin
              // set up main in slot 0 when the table is empty
              if (stat_i.empty) begin
                cmd_o.addr_sel = A_ZERO;
                cmd_o.wr_op    = WR_MAIN;
              end
              state_d = S_FS_INIT;
            end
          end
          CMD_EXIT: begin
            cmd_o.addr_sel = A_ACTIVE;
            state_d = S_EX_CHK;
          end
          CMD_JOIN: begin
            if (stat_i.tgt_ok) begin
              cmd_o.addr_sel = A_TARGET;
              state_d = S_JN_CHKT;
            end else begin
              state_d = S_RS_INIT;
            end
          end
          CMD_TICK: state_d = S_RS_INIT;
          default:  state_d = S_RS_INIT;
        endcase
      end
      S_FS_INIT: begin
        cmd_o.scan_init = 1'b1;
        cmd_o.scan_mode = SCAN_FREE;
        state_d = S_FS_RUN;
      end
      S_FS_RUN: begin
        cmd_o.scan_mode = SCAN_FREE;
        if (stat_i.hit) begin
          cmd_o.addr_sel = A_HIT;
          cmd_o.wr_op    = WR_NEW;
          state_d = S_RS_INIT;
        end else if (stat_i.miss) begin
          cmd_o.set_refused = 1'b1;
          state_d = S_RS_INIT;
        end else begin
          cmd_o.addr_sel  = A_SCAN;
          cmd_o.scan_step = 1'b1;
        end
      end
      S_EX_CHK: begin
        state_d = S_RS_INIT;
        if (!stat_i.rd_dead) begin
          cmd_o.addr_sel = A_ACTIVE;
          cmd_o.wr_op    = WR_EXIT;
          if (stat_i.rd_jv) state_d = S_WK_RD;
        end
      end
      S_WK_RD: begin
        cmd_o.addr_sel = A_JOINER;
        state_d = S_WK_CHK;
      end
      S_WK_CHK: begin
        // restore the joiner only while it is still blocked
        if (stat_i.rd_blocked) begin
          cmd_o.addr_sel = A_JOINER;
          cmd_o.wr_op    = WR_WAKE;
        end
        state_d = S_RS_INIT;
      end
      S_JN_CHKT: begin
        cmd_o.addr_sel = A_ACTIVE;
        state_d = (stat_i.rd_runnable && !stat_i.rd_jv) ? S_JN_CHKA : S_RS_INIT;
      end
      S_JN_CHKA: begin
        if (stat_i.rd_runnable) begin
          cmd_o.addr_sel = A_ACTIVE;
          cmd_o.wr_op    = WR_BLOCK;
          state_d = S_JN_WRT;
        end else begin
          state_d = S_RS_INIT;
        end
      end
      S_JN_WRT: begin
        cmd_o.addr_sel = A_TARGET;
        cmd_o.wr_op    = WR_JOIN;
        state_d = S_RS_INIT;
      end
      S_RS_INIT: begin
        cmd_o.scan_init = 1'b1;
        cmd_o.scan_mode = SCAN_READY;
        state_d = S_RS_RUN;
      end
      S_RS_RUN: begin
        cmd_o.scan_mode = SCAN_READY;
        if (stat_i.hit) begin
          cmd_o.take_hit = 1'b1;
          state_d = S_ACT_RD;
        end else if (stat_i.miss) begin
          state_d = S_ACT_RD;
        end else begin
          cmd_o.addr_sel  = A_SCAN;
          cmd_o.scan_step = 1'b1;
        end
      end
      S_ACT_RD: begin
        cmd_o.addr_sel = A_ACTIVE;
        state_d = S_ACT_CHK;
      end
      S_ACT_CHK: begin
        cmd_o.latch_tid = 1'b1;
        state_d = S_DONE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= CMD_TICK;
    end else begin
      state_q <= state_d;
      if (accept) cmd_q <= command_i;
    end
  end

endmodule

FILE: hdl/rrtt_checker.sv
// ----------------------------------------------------------------------------
// rrtt_checker
// Port-level checks on the command handshake and result strobe, bound to
// the top level.
// ----------------------------------------------------------------------------
module rrtt_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic                                done_o,
  input logic                                status_o,
  input logic [rrtt_pkg::SLOT_FIELD_W-1:0]   new_slot_o,
  input logic [rrtt_pkg::ID_W-1:0]           new_tid_o
);

  // an accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after an accepted item");

  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("busy raised during the result strobe");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // a refused create reports no new thread
  a_refused_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> (new_slot_o == '0 && new_tid_o == '0))
    else $error("refused create reports a new thread");

endmodule

bind round_robin_thread_table_top rrtt_checker u_checker (.*);

FILE: bench/tb_round_robin_thread_table_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_round_robin_thread_table_top
// Drives tick, create, exit and join commands into the thread table and checks
// every done strobe against a cycle-free model of the slot table and the
// round-robin pick. The commands come as a short hand-written opening, then
// random phases that fill the table, churn it and drain it again. The commands
// go in in bursts with random gaps.
// ----------------------------------------------------------------------------
module tb_round_robin_thread_table_top;
  import rrtt_pkg::*;

  localparam int SLOTS = THREAD_SLOTS_DEF;

  typedef struct packed {
    logic [1:0]               command;
    logic [SLOT_FIELD_W-1:0]  target;
  } table_cmd_t;

  typedef struct packed {
    logic                     status;
    logic [SLOT_FIELD_W-1:0]  new_slot;
    logic [ID_W-1:0]          new_id;
    logic [SLOT_FIELD_W-1:0]  act_slot;
    logic [ID_W-1:0]          act_id;
    logic [COUNT_FIELD_W-1:0] live;
  } sched_result_t;

  logic                     clk_i     = 1'b0;
  logic                     rst_ni    = 1'b0;
  logic                     start_r   = 1'b0;
  logic [1:0]               command_r = CMD_TICK;
  logic [SLOT_FIELD_W-1:0]  target_r  = '0;
  logic                     busy;
  logic                     done_o;
  logic                     status_o;
  logic [SLOT_FIELD_W-1:0]  new_slot_o;
  logic [ID_W-1:0]          new_tid_o;
  logic [SLOT_FIELD_W-1:0]  active_slot_o;
  logic [ID_W-1:0]          active_thread_id_o;
  logic [COUNT_FIELD_W-1:0] live_count_o;

  round_robin_thread_table_top uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start_r),
    .busy               (busy),
    .command_i          (command_r),
    .target_slot_i      (target_r),
    .done_o             (done_o),
    .status_o           (status_o),
    .new_slot_o         (new_slot_o),
    .new_tid_o          (new_tid_o),
    .active_slot_o      (active_slot_o),
    .active_thread_id_o (active_thread_id_o),
    .live_count_o       (live_count_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // model of the slot table
  logic [2:0]              slot_st  [SLOTS];
  logic [ID_W-1:0]         slot_tid [SLOTS];
  logic [2:0]              slot_sav [SLOTS];
  logic [SLOT_FIELD_W-1:0] slot_jn  [SLOTS];
  logic                    slot_jv  [SLOTS];
  int                      act_idx  = 0;
  int                      live_thr = 0;
  logic [ID_W-1:0]         next_tid = FIRST_ID;

  table_cmd_t    cmd_backlog[$];
  sched_result_t expected_sched[$];
  int            mismatches = 0;
  int            burst_left = 0;
  int            gap_left   = 0;

  initial begin
    for (int k = 0; k < SLOTS; k++) begin
      slot_st[k]  = ST_FREE;
      slot_tid[k] = '0;
      slot_sav[k] = ST_FREE;
      slot_jn[k]  = '0;
      slot_jv[k]  = 1'b0;
    end
  end

  function automatic sched_result_t step_thread_table(logic [1:0] cmd,
                                                      logic [SLOT_FIELD_W-1:0] tgt);
    sched_result_t r;
    int            a;
    int            i;
    int            pos;
    int            hit;
    int            j;
    logic [2:0]    ts;
    logic [2:0]    as;
    r   = '0;
    a   = act_idx % SLOTS;
    hit = -1;
    case (cmd)
      CMD_CREATE: begin
        if (live_thr >= SLOTS) begin
          r.status = 1'b1;
        end else begin
          if (live_thr == 0) begin
            slot_tid[0] = MAIN_ID;
            slot_st[0]  = ST_READY;
            slot_jv[0]  = 1'b0;
            live_thr    = 1;
          end
          // lowest free or exited slot above main
          for (i = 1; i < SLOTS; i++)
            if (hit < 0 && (slot_st[i] == ST_FREE || slot_st[i] == ST_EXITED))
              hit = i;
          if (hit < 0) begin
            r.status = 1'b1;
          end else begin
            slot_tid[hit] = next_tid;
            r.new_slot    = hit[SLOT_FIELD_W-1:0];
            r.new_id      = next_tid;
            next_tid      = next_tid + 1'b1;
            slot_st[hit]  = ST_READY;
            slot_sav[hit] = ST_FREE;
            slot_jv[hit]  = 1'b0;
            live_thr++;
          end
        end
      end
      CMD_EXIT: begin
        if (slot_st[a] != ST_FREE && slot_st[a] != ST_EXITED) begin
          slot_st[a] = ST_EXITED;
          if (slot_jv[a]) begin
            j = int'(slot_jn[a]) % SLOTS;
            // wake the joiner only while it is still blocked
            if (slot_st[j] == ST_BLOCKED) slot_st[j] = slot_sav[j];
            slot_jv[a] = 1'b0;
          end
          if (live_thr > 0) live_thr--;
        end
      end
      CMD_JOIN: begin
        if (int'(tgt) < SLOTS) begin
          ts = slot_st[tgt];
          as = slot_st[a];
          if ((ts == ST_READY || ts == ST_RUNNING) && !slot_jv[tgt] &&
              (as == ST_READY || as == ST_RUNNING)) begin
            slot_sav[a]  = as;
            slot_st[a]   = ST_BLOCKED;
            slot_jn[tgt] = a[SLOT_FIELD_W-1:0];
            slot_jv[tgt] = 1'b1;
          end
        end
      end
      default: ;
    endcase
    // round-robin pick, active slot stays if nothing is ready
    act_idx = a;
    pos     = a;
    hit     = -1;
    for (i = 0; i < SLOTS; i++) begin
      pos = (pos + 1) % SLOTS;
      if (hit < 0 && slot_st[pos] == ST_READY) hit = pos;
    end
    if (hit >= 0) act_idx = hit;
    r.act_slot = act_idx[SLOT_FIELD_W-1:0];
    r.act_id   = (slot_st[act_idx] == ST_FREE) ? '0 : slot_tid[act_idx];
    r.live     = live_thr[COUNT_FIELD_W-1:0];
    return r;
  endfunction

  // driver: hold the item on the port until it is taken
  always @(posedge clk_i) begin
    table_cmd_t nxt;
    logic       port_free;
    if (!rst_ni) begin
      start_r <= 1'b0;
    end else begin
      port_free = !start_r || !busy;
      if (start_r && !busy)
        expected_sched.push_back(step_thread_table(command_r, target_r));
      if (port_free) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start_r  <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          nxt = cmd_backlog.pop_front();
          command_r <= nxt.command;
          target_r  <= nxt.target;
          start_r   <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 16);
            case ($urandom_range(0, 7))
              0:       gap_left <= $urandom_range(100, 300);
              1, 2, 3: gap_left <= 0;
              default: gap_left <= $urandom_range(1, 8);
            endcase
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start_r <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [ID_W-1:0] exp_v, logic [ID_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // monitor: a result is there for one cycle only
  always @(posedge clk_i) begin
    sched_result_t e;
    if (rst_ni && done_o) begin
      if (expected_sched.size() == 0) begin
        $error("result with no command outstanding");
        mismatches++;
      end else begin
        e = expected_sched.pop_front();
        check_field("status", ID_W'(e.status), ID_W'(status_o));
        check_field("new_slot", ID_W'(e.new_slot), ID_W'(new_slot_o));
        check_field("new_tid", e.new_id, new_tid_o);
        check_field("active_slot", ID_W'(e.act_slot), ID_W'(active_slot_o));
        check_field("active_thread_id", e.act_id, active_thread_id_o);
        check_field("live_count", ID_W'(e.live), ID_W'(live_count_o));
      end
    end
  end

  task automatic add_cmd(logic [1:0] cmd, logic [SLOT_FIELD_W-1:0] tgt);
    table_cmd_t c;
    c.command = cmd;
    c.target  = tgt;
    cmd_backlog.push_back(c);
  endtask

  // weights out of 100; the rest are ticks
  task automatic random_phase(int n, int w_create, int w_exit, int w_join);
    int                      roll;
    logic [SLOT_FIELD_W-1:0] tgt;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      // aim joins mostly at the low slots, where the threads live
      tgt = ($urandom_range(0, 3) != 0) ? SLOT_FIELD_W'($urandom_range(0, 15))
                                        : SLOT_FIELD_W'($urandom_range(0, SLOTS - 1));
      if (roll < w_create)                         add_cmd(CMD_CREATE, tgt);
      else if (roll < w_create + w_exit)           add_cmd(CMD_EXIT, tgt);
      else if (roll < w_create + w_exit + w_join)  add_cmd(CMD_JOIN, tgt);
      else                                         add_cmd(CMD_TICK, tgt);
    end
  endtask

  initial begin
    // empty table: dead exit, rejected join, plain tick
    add_cmd(CMD_EXIT, 7'd0);
    add_cmd(CMD_JOIN, 7'd0);
    add_cmd(CMD_TICK, 7'd127);
    // first create sets up main
    add_cmd(CMD_CREATE, 7'd0);
    add_cmd(CMD_CREATE, 7'd127);
    add_cmd(CMD_JOIN, 7'd127);
    add_cmd(CMD_JOIN, 7'd2);
    add_cmd(CMD_JOIN, 7'd2);
    add_cmd(CMD_JOIN, 7'd1);
    add_cmd(CMD_JOIN, 7'd1);
    add_cmd(CMD_TICK, 7'd0);
    add_cmd(CMD_EXIT, 7'd0);
    add_cmd(CMD_JOIN, 7'd1);
    add_cmd(CMD_CREATE, 7'd64);
    add_cmd(CMD_JOIN, 7'd0);
    add_cmd(CMD_TICK, 7'd85);
    add_cmd(CMD_EXIT, 7'd42);
    add_cmd(CMD_EXIT, 7'd0);
    add_cmd(CMD_CREATE, 7'd0);
    add_cmd(CMD_TICK, 7'd0);
    add_cmd(CMD_EXIT, 7'd0);
    add_cmd(CMD_EXIT, 7'd0);

    // fill to the top, churn, refill with main gone, churn, drain
    random_phase(150, 95, 2, 2);
    random_phase(120, 25, 25, 35);
    random_phase(120, 85, 5, 5);
    random_phase(120, 20, 30, 40);
    random_phase(100, 5, 80, 5);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_backlog.size() != 0 || start_r || expected_sched.size() != 0)
      @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
